// ===== src/ucrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucrd_pkg
// Shared types and constants of the USB Type-C role detector.
// ----------------------------------------------------------------------------
package ucrd_pkg;

    localparam int CC_BITS   = 12;
    localparam int CNT_BITS  = 8;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        ROLE_IDLE    = 2'd0,
        ROLE_DEVICE  = 2'd1,
        ROLE_HOST    = 2'd2,
        ROLE_UNKNOWN = 2'd3
    } role_t;

    typedef enum logic [2:0] {
        REG_IDLE_DEBOUNCE  = 3'd0,
        REG_CHATTER_LIMIT  = 3'd1,
        REG_CC_FLOOR       = 3'd2,
        REG_CC_CEILING     = 3'd3,
        REG_HOST_ALLOWED   = 3'd4,
        REG_DEVICE_ALLOWED = 3'd5,
        REG_SPARE_6        = 3'd6,
        REG_SPARE_7        = 3'd7
    } reg_index_t;

    localparam logic [CNT_BITS-1:0] IDLE_DEBOUNCE_RESET = CNT_BITS'(10);
    localparam logic [CNT_BITS-1:0] CHATTER_LIMIT_RESET = CNT_BITS'(20);
    localparam logic [CC_BITS-1:0]  CC_FLOOR_RESET      = CC_BITS'(4095 / 20);
    localparam logic [CC_BITS-1:0]  CC_CEILING_RESET    = CC_BITS'(1000);
    localparam logic [CNT_BITS-1:0] CNT_MAX             = {CNT_BITS{1'b1}};

    typedef struct packed {
        logic [CNT_BITS-1:0] idle_debounce_needed;
        logic [CNT_BITS-1:0] chatter_limit;
        logic [CC_BITS-1:0]  cc_floor;
        logic [CC_BITS-1:0]  cc_ceiling;
        logic                host_role_allowed;
        logic                device_role_allowed;
    } cfg_t;

    typedef struct packed {
        logic        vbus_sense;
        logic        enable_sense;
        logic [11:0] cc1_level;
        logic [11:0] cc2_level;
        logic        sense_ok;
        logic        start_ok;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] role;
        logic       enable_drive;
        logic       ufp_drive;
        logic       host_start;
        logic       device_start;
        logic       host_stop;
        logic       device_stop;
        logic       device_ready;
        logic       role_entry;
    } out_beat_t;

endpackage

// ===== src/ucrd_regs.sv =====
// ----------------------------------------------------------------------------
// ucrd_regs
// APB-style configuration registers of the role detector.
// ----------------------------------------------------------------------------
module ucrd_regs import ucrd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_debounce_needed <= IDLE_DEBOUNCE_RESET;
            cfg_reg.chatter_limit        <= CHATTER_LIMIT_RESET;
            cfg_reg.cc_floor             <= CC_FLOOR_RESET;
            cfg_reg.cc_ceiling           <= CC_CEILING_RESET;
            cfg_reg.host_role_allowed    <= 1'b1;
            cfg_reg.device_role_allowed  <= 1'b1;
        end else if (wr_en) begin
            unique case (index)
                REG_IDLE_DEBOUNCE:  cfg_reg.idle_debounce_needed <= pwdata[CNT_BITS-1:0];
                REG_CHATTER_LIMIT:  cfg_reg.chatter_limit        <= pwdata[CNT_BITS-1:0];
                REG_CC_FLOOR:       cfg_reg.cc_floor             <= pwdata[CC_BITS-1:0];
                REG_CC_CEILING:     cfg_reg.cc_ceiling           <= pwdata[CC_BITS-1:0];
                REG_HOST_ALLOWED:   cfg_reg.host_role_allowed    <= pwdata[0];
                REG_DEVICE_ALLOWED: cfg_reg.device_role_allowed  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (index)
            REG_IDLE_DEBOUNCE:  prdata = DATA_BITS'(cfg_reg.idle_debounce_needed);
            REG_CHATTER_LIMIT:  prdata = DATA_BITS'(cfg_reg.chatter_limit);
            REG_CC_FLOOR:       prdata = DATA_BITS'(cfg_reg.cc_floor);
            REG_CC_CEILING:     prdata = DATA_BITS'(cfg_reg.cc_ceiling);
            REG_HOST_ALLOWED:   prdata = DATA_BITS'(cfg_reg.host_role_allowed);
            REG_DEVICE_ALLOWED: prdata = DATA_BITS'(cfg_reg.device_role_allowed);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== src/ucrd_core.sv =====
// ----------------------------------------------------------------------------
// ucrd_core
// Role state, debounce and chatter counters, and the per-tick update.
// ----------------------------------------------------------------------------
module ucrd_core import ucrd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      step,
    input  in_beat_t  beat,
    output out_beat_t result
);

    role_t               role_reg, role_next;
    logic                pend_reg, pend_next;
    role_t               cand_reg, cand_next;
    logic [CNT_BITS-1:0] match_reg, match_next;
    logic [CNT_BITS-1:0] miss_reg, miss_next;
    logic                hs_reg, hs_next;
    logic                ds_reg, ds_next;
    logic                dr_reg, dr_next;

    role_t               sensed;
    logic                cc1_hit, cc2_hit;
    logic [CNT_BITS-1:0] match_inc, miss_inc;
    logic                h_start, d_start, h_stop, d_stop, entry;

    assign cc1_hit = (beat.cc1_level[CC_BITS-1:0] > cfg.cc_floor) &&
                     (beat.cc1_level[CC_BITS-1:0] < cfg.cc_ceiling);
    assign cc2_hit = (beat.cc2_level[CC_BITS-1:0] > cfg.cc_floor) &&
                     (beat.cc2_level[CC_BITS-1:0] < cfg.cc_ceiling);

    always_comb begin
        if (!beat.sense_ok) begin
            sensed = ROLE_UNKNOWN;
        end else if (beat.vbus_sense && !beat.enable_sense) begin
            sensed = ROLE_DEVICE;
        end else if (cc1_hit || cc2_hit) begin
            sensed = ROLE_HOST;
        end else begin
            sensed = ROLE_IDLE;
        end
    end

    assign match_inc = (match_reg == CNT_MAX) ? match_reg : match_reg + CNT_BITS'(1);
    assign miss_inc  = (miss_reg == CNT_MAX) ? miss_reg : miss_reg + CNT_BITS'(1);

    always_comb begin
        role_next  = role_reg;
        pend_next  = pend_reg;
        cand_next  = cand_reg;
        match_next = match_reg;
        miss_next  = miss_reg;
        hs_next    = hs_reg;
        ds_next    = ds_reg;
        dr_next    = dr_reg;
        h_start    = 1'b0;
        d_start    = 1'b0;
        h_stop     = 1'b0;
        d_stop     = 1'b0;
        entry      = 1'b0;
        unique case (role_reg)
            ROLE_IDLE: begin
                if (pend_reg) begin
                    h_stop    = 1'b1;
                    d_stop    = 1'b1;
                    hs_next   = 1'b0;
                    ds_next   = 1'b0;
                    dr_next   = 1'b0;
                    pend_next = 1'b0;
                    entry     = 1'b1;
                end else if (sensed == ROLE_UNKNOWN || sensed == ROLE_IDLE) begin
                    match_next = '0;
                    cand_next  = ROLE_IDLE;
                end else if (sensed != cand_reg) begin
                    cand_next  = sensed;
                    match_next = '0;
                end else begin
                    match_next = match_inc;
                    if (match_inc >= cfg.idle_debounce_needed) begin
                        role_next = sensed;
                        pend_next = 1'b1;
                    end
                end
            end
            ROLE_HOST, ROLE_DEVICE: begin
                if (role_reg == ROLE_HOST) begin
                    d_stop  = 1'b1;
                    ds_next = 1'b0;
                    dr_next = 1'b0;
                end else begin
                    h_stop  = 1'b1;
                    hs_next = 1'b0;
                end
                if (pend_reg) begin
                    pend_next = 1'b0;
                    miss_next = '0;
                    entry     = 1'b1;
                    if (role_reg == ROLE_HOST) begin
                        hs_next = 1'b0;
                    end else begin
                        ds_next = 1'b0;
                    end
                end else if (sensed != role_reg) begin
                    miss_next = miss_inc;
                    if (miss_inc >= cfg.chatter_limit) begin
                        role_next = ROLE_IDLE;
                        pend_next = 1'b1;
                        miss_next = '0;
                    end
                end else begin
                    miss_next = '0;
                    if (role_reg == ROLE_HOST) begin
                        if (!hs_reg && cfg.host_role_allowed) begin
                            h_start = 1'b1;
                            if (beat.start_ok) begin
                                hs_next = 1'b1;
                            end
                        end
                    end else begin
                        if (!ds_reg && cfg.device_role_allowed) begin
                            d_start = 1'b1;
                            ds_next = beat.start_ok;
                            dr_next = beat.start_ok;
                        end
                    end
                end
            end
            default: begin
                role_next = ROLE_IDLE;
                pend_next = 1'b1;
            end
        endcase
    end

    always_comb begin
        result.role         = role_next;
        result.enable_drive = (role_next == ROLE_HOST) && !pend_next;
        result.ufp_drive    = (role_next == ROLE_DEVICE) && !pend_next;
        result.host_start   = h_start;
        result.device_start = d_start;
        result.host_stop    = h_stop;
        result.device_stop  = d_stop;
        result.device_ready = dr_next;
        result.role_entry   = entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_reg  <= ROLE_IDLE;
            pend_reg  <= 1'b1;
            cand_reg  <= ROLE_IDLE;
            match_reg <= '0;
            miss_reg  <= '0;
            hs_reg    <= 1'b0;
            ds_reg    <= 1'b0;
            dr_reg    <= 1'b0;
        end else if (step) begin
            role_reg  <= role_next;
            pend_reg  <= pend_next;
            cand_reg  <= cand_next;
            match_reg <= match_next;
            miss_reg  <= miss_next;
            hs_reg    <= hs_next;
            ds_reg    <= ds_next;
            dr_reg    <= dr_next;
        end
    end

endmodule

// ===== src/usb_c_role_detector.sv =====
// ----------------------------------------------------------------------------
// usb_c_role_detector
// USB Type-C role detection with idle debounce and active-role chatter limit.
// ----------------------------------------------------------------------------
// Each accepted input beat is one sensing tick and yields exactly one result
// beat. A beat is captured in an input register, its role update is computed
// combinationally against the role state, and the result lands in an output
// register, so a result passes the input register and then the output
// register before it is offered, and a new beat can be accepted every cycle
// as long as results are taken. The input side stalls only while the input
// register holds a beat and the output register holds an untaken result.
module usb_c_role_detector import ucrd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t      cfg;
    in_beat_t  in_data_reg;
    logic      in_valid_reg;
    out_beat_t out_data_reg;
    logic      out_valid_reg;
    out_beat_t result;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    ucrd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ucrd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .beat    (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== verif/usb_c_role_detector_tb.sv =====
// ----------------------------------------------------------------------------
// usb_c_role_detector_tb
// Self-checking bench for the USB Type-C role detector. A scoreboard class
// predicts every result beat from the accepted tick beats and the register
// settings, and checks each result beat field by field. Directed ticks walk
// the role changes first. Several register settings follow, each with random
// role segments, noise and random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module usb_c_role_detector_tb import ucrd_pkg::*;;

    class role_scoreboard;
        cfg_t                cfg;
        role_t               role_now;
        role_t               cand_role;
        logic                entry_due;
        logic [CNT_BITS-1:0] match_cnt;
        logic [CNT_BITS-1:0] miss_cnt;
        logic                host_up;
        logic                dev_up;
        logic                dev_ready;
        out_beat_t           expected_q[$];
        int                  errors;
        int                  n_seen;

        function new();
            cfg.idle_debounce_needed = IDLE_DEBOUNCE_RESET;
            cfg.chatter_limit        = CHATTER_LIMIT_RESET;
            cfg.cc_floor             = CC_FLOOR_RESET;
            cfg.cc_ceiling           = CC_CEILING_RESET;
            cfg.host_role_allowed    = 1'b1;
            cfg.device_role_allowed  = 1'b1;
            role_now  = ROLE_IDLE;
            cand_role = ROLE_IDLE;
            entry_due = 1'b1;
            match_cnt = '0;
            miss_cnt  = '0;
            host_up   = 1'b0;
            dev_up    = 1'b0;
            dev_ready = 1'b0;
            errors    = 0;
            n_seen    = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [DATA_BITS-1:0] val);
            case (idx)
                REG_IDLE_DEBOUNCE:  cfg.idle_debounce_needed = val[CNT_BITS-1:0];
                REG_CHATTER_LIMIT:  cfg.chatter_limit        = val[CNT_BITS-1:0];
                REG_CC_FLOOR:       cfg.cc_floor             = val[CC_BITS-1:0];
                REG_CC_CEILING:     cfg.cc_ceiling           = val[CC_BITS-1:0];
                REG_HOST_ALLOWED:   cfg.host_role_allowed    = val[0];
                REG_DEVICE_ALLOWED: cfg.device_role_allowed  = val[0];
                default: ;
            endcase
        endfunction

        function bit in_window(logic [CC_BITS-1:0] v);
            return v > cfg.cc_floor && v < cfg.cc_ceiling;
        endfunction

        function role_t sense(in_beat_t b);
            if (!b.sense_ok) return ROLE_UNKNOWN;
            if (b.vbus_sense && !b.enable_sense) return ROLE_DEVICE;
            if (in_window(b.cc1_level) || in_window(b.cc2_level)) return ROLE_HOST;
            return ROLE_IDLE;
        endfunction

        function logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] v);
            return (v == CNT_MAX) ? v : v + CNT_BITS'(1);
        endfunction

        function void note_tick(in_beat_t b);
            out_beat_t o;
            role_t     seen;
            logic      was_host;
            o = '0;
            was_host = (role_now == ROLE_HOST);
            case (role_now)
                ROLE_IDLE: begin
                    if (entry_due) begin
                        o.host_stop   = 1'b1;
                        o.device_stop = 1'b1;
                        host_up       = 1'b0;
                        dev_up        = 1'b0;
                        dev_ready     = 1'b0;
                        entry_due     = 1'b0;
                        o.role_entry  = 1'b1;
                    end else begin
                        seen = sense(b);
                        if (seen == ROLE_UNKNOWN || seen == ROLE_IDLE) begin
                            match_cnt = '0;
                            cand_role = ROLE_IDLE;
                        end else if (seen != cand_role) begin
                            cand_role = seen;
                            match_cnt = '0;
                        end else begin
                            match_cnt = bump(match_cnt);
                            if (match_cnt >= cfg.idle_debounce_needed) begin
                                role_now  = seen;
                                entry_due = 1'b1;
                            end
                        end
                    end
                end
                ROLE_HOST, ROLE_DEVICE: begin
                    if (was_host) begin
                        o.device_stop = 1'b1;
                        dev_up        = 1'b0;
                        dev_ready     = 1'b0;
                    end else begin
                        o.host_stop = 1'b1;
                        host_up     = 1'b0;
                    end
                    if (entry_due) begin
                        entry_due = 1'b0;
                        if (was_host) begin
                            host_up = 1'b0;
                        end else begin
                            dev_up = 1'b0;
                        end
                        miss_cnt     = '0;
                        o.role_entry = 1'b1;
                    end else if (sense(b) != role_now) begin
                        miss_cnt = bump(miss_cnt);
                        if (miss_cnt >= cfg.chatter_limit) begin
                            role_now  = ROLE_IDLE;
                            entry_due = 1'b1;
                            miss_cnt  = '0;
                        end
                    end else begin
                        miss_cnt = '0;
                        if (was_host) begin
                            if (!host_up && cfg.host_role_allowed) begin
                                o.host_start = 1'b1;
                                if (b.start_ok) host_up = 1'b1;
                            end
                        end else if (!dev_up && cfg.device_role_allowed) begin
                            o.device_start = 1'b1;
                            dev_up         = b.start_ok;
                            dev_ready      = b.start_ok;
                        end
                    end
                end
                default: begin
                    role_now  = ROLE_IDLE;
                    entry_due = 1'b1;
                end
            endcase
            o.role         = role_now;
            o.enable_drive = (role_now == ROLE_HOST) && !entry_due;
            o.ufp_drive    = (role_now == ROLE_DEVICE) && !entry_due;
            o.device_ready = dev_ready;
            expected_q.push_back(o);
        endfunction

        function string show(out_beat_t o);
            return $sformatf({"role=%0d en=%0b ufp=%0b hstart=%0b dstart=%0b ",
                              "hstop=%0b dstop=%0b ready=%0b entry=%0b"},
                             o.role, o.enable_drive, o.ufp_drive, o.host_start,
                             o.device_start, o.host_stop, o.device_stop,
                             o.device_ready, o.role_entry);
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            n_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("beat %0d: result with no tick pending: %s",
                                           n_seen, show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.role !== want.role || got.enable_drive !== want.enable_drive ||
                got.ufp_drive !== want.ufp_drive || got.host_start !== want.host_start ||
                got.device_start !== want.device_start ||
                got.host_stop !== want.host_stop || got.device_stop !== want.device_stop ||
                got.device_ready !== want.device_ready ||
                got.role_entry !== want.role_entry) begin
                errors++;
                if (errors <= 10) begin
                    $display("beat %0d mismatch: expected %s", n_seen, show(want));
                    $display("beat %0d mismatch: actual   %s", n_seen, show(got));
                end
            end
        endfunction
    endclass

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_beat_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    role_scoreboard sb;
    bit             tx_calm  = 1'b0;
    bit             rx_calm  = 1'b0;
    int             stall_left = 0;
    int             rx_roll;

    usb_c_role_detector DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        rx_roll = $urandom_range(999, 0);
        if (rx_roll < 3) rx_calm <= ~rx_calm;
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!rx_calm && rx_roll >= 650) begin
            m_ready    <= 1'b0;
            stall_left <= (rx_roll >= 985) ? $urandom_range(40, 12) : $urandom_range(2, 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_tick(s_data);
            if (m_valid && m_ready) sb.check_beat(m_data);
        end
    end

    function automatic bit window_open();
        return int'(sb.cfg.cc_ceiling) > int'(sb.cfg.cc_floor) + 1;
    endfunction

    function automatic int cc_inside();
        int lo;
        int hi;
        lo = int'(sb.cfg.cc_floor) + 1;
        hi = int'(sb.cfg.cc_ceiling) - 1;
        case ($urandom_range(3, 0))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic int cc_outside();
        if (!window_open()) return $urandom_range(4095, 0);
        case ($urandom_range(3, 0))
            0:       return int'(sb.cfg.cc_floor);
            1:       return int'(sb.cfg.cc_ceiling);
            2:       return $urandom_range(int'(sb.cfg.cc_floor), 0);
            default: return $urandom_range(4095, int'(sb.cfg.cc_ceiling));
        endcase
    endfunction

    function automatic in_beat_t make_tick(role_t want, bit raw);
        in_beat_t    b;
        logic [31:0] r;
        r = $urandom;
        b = r[$bits(in_beat_t)-1:0];
        if (raw) return b;
        b.start_ok = ($urandom_range(3, 0) != 0);
        case (want)
            ROLE_UNKNOWN: b.sense_ok = 1'b0;
            ROLE_DEVICE: begin
                b.sense_ok     = 1'b1;
                b.vbus_sense   = 1'b1;
                b.enable_sense = 1'b0;
            end
            ROLE_HOST: begin
                b.sense_ok = 1'b1;
                if (b.vbus_sense && !b.enable_sense) b.enable_sense = 1'b1;
                if (window_open()) begin
                    if ($urandom_range(1, 0)) begin
                        b.cc1_level = 12'(cc_inside());
                    end else begin
                        b.cc2_level = 12'(cc_inside());
                    end
                end
            end
            default: begin
                b.sense_ok = 1'b1;
                if (b.vbus_sense && !b.enable_sense) b.enable_sense = 1'b1;
                b.cc1_level = 12'(cc_outside());
                b.cc2_level = 12'(cc_outside());
            end
        endcase
        return b;
    endfunction

    function automatic in_beat_t mk(bit vbus, bit en, int cc1, int cc2, bit ok, bit st);
        in_beat_t b;
        b.vbus_sense   = vbus;
        b.enable_sense = en;
        b.cc1_level    = 12'(cc1);
        b.cc2_level    = 12'(cc2);
        b.sense_ok     = ok;
        b.start_ok     = st;
        return b;
    endfunction

    function automatic int tx_gap();
        int k;
        if (tx_calm) return 0;
        k = $urandom_range(99, 0);
        if (k < 65) return 0;
        if (k < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 12);
    endfunction

    task automatic send_tick(input in_beat_t b);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_all();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [DATA_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * int'(idx));
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int deb, input int chat, input int flo, input int ceil,
                              input bit host_ok, input bit dev_ok);
        drain_all();
        apb_write(REG_IDLE_DEBOUNCE, DATA_BITS'(deb));
        apb_write(REG_CHATTER_LIMIT, DATA_BITS'(chat));
        apb_write(REG_CC_FLOOR, DATA_BITS'(flo));
        apb_write(REG_CC_CEILING, DATA_BITS'(ceil));
        apb_write(REG_HOST_ALLOWED, DATA_BITS'(host_ok));
        apb_write(REG_DEVICE_ALLOWED, DATA_BITS'(dev_ok));
    endtask

    task automatic random_ticks(input int n);
        int    sent;
        int    len;
        int    k;
        int    deb;
        int    chat;
        bit    noise;
        role_t want;
        sent = 0;
        deb  = int'(sb.cfg.idle_debounce_needed);
        chat = int'(sb.cfg.chatter_limit);
        while (sent < n) begin
            k     = $urandom_range(99, 0);
            noise = (k >= 90);
            want  = (k < 35) ? ROLE_DEVICE : (k < 70) ? ROLE_HOST :
                    (k < 83) ? ROLE_IDLE : ROLE_UNKNOWN;
            len   = ($urandom_range(2, 0) == 0) ? $urandom_range(6, 1) :
                    $urandom_range(deb + chat + 10, deb + 1);
            tx_calm = ($urandom_range(4, 0) == 0);
            for (int i = 0; i < len && sent < n; i++) begin
                send_tick(make_tick(want, noise || $urandom_range(19, 0) == 0));
                sent++;
            end
            if ($urandom_range(24, 0) == 0) drain_all();
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short limits so that every role change shows up within a few ticks.
        set_config(1, 1, 204, 1000, 1'b1, 1'b1);
        send_tick(mk(0, 0, 0, 0, 1, 0));
        send_tick(mk(1, 0, 4095, 4095, 1, 1));
        send_tick(mk(1, 0, 4095, 0, 1, 1));
        send_tick(mk(1, 0, 0, 4095, 1, 1));
        send_tick(mk(1, 0, 0, 0, 1, 0));
        send_tick(mk(1, 0, 4095, 4095, 1, 1));
        send_tick(mk(1, 0, 300, 300, 1, 1));
        send_tick(mk(1, 1, 4095, 4095, 0, 1));
        send_tick(mk(0, 0, 0, 0, 1, 1));
        send_tick(mk(0, 1, 205, 0, 1, 0));
        send_tick(mk(1, 1, 0, 999, 1, 0));
        send_tick(mk(0, 0, 500, 500, 1, 1));
        send_tick(mk(0, 0, 999, 4095, 1, 0));
        send_tick(mk(0, 0, 4095, 205, 1, 1));
        send_tick(mk(0, 0, 600, 600, 1, 1));
        send_tick(mk(0, 0, 204, 1000, 1, 1));
        send_tick(mk(0, 0, 0, 0, 1, 0));
        send_tick(mk(0, 0, 700, 0, 1, 1));
        send_tick(mk(1, 0, 700, 0, 1, 1));
        send_tick(mk(1, 0, 0, 0, 1, 1));
        send_tick(mk(1, 0, 0, 0, 1, 1));
        send_tick(mk(0, 0, 500, 0, 1, 1));
        send_tick(mk(0, 0, 0, 0, 1, 1));
        send_tick(mk(1, 1, 0, 0, 0, 0));
        send_tick(mk(1, 1, 4095, 4095, 1, 1));

        set_config(0, 0, 0, 4095, 1'b1, 1'b1);
        random_ticks(150);
        set_config(255, 255, 100, 3000, 1'b1, 1'b0);
        random_ticks(400);
        set_config(3, 4, 4095, 0, 1'b1, 1'b1);
        random_ticks(200);
        set_config(5, 2, 204, 1000, 1'b0, 1'b0);
        random_ticks(200);
        set_config(2, 6, 2000, 2003, 1'b1, 1'b1);
        random_ticks(300);
        set_config(1, 255, 0, 2, 1'b1, 1'b1);
        random_ticks(200);

        drain_all();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** usb_c_role_detector: PASSED **");
        end else begin
            $display("** usb_c_role_detector: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** usb_c_role_detector: FAILED **");
        $finish;
    end

endmodule
